// ===== rtl/core/det_pkg.sv =====
// ----------------------------------------------------------------------------
// det_pkg
// Shared types, constants and helpers for the directory entry table.
// ----------------------------------------------------------------------------
package det_pkg;

  localparam int unsigned MAX_ENTRIES_DEF = 32;
  localparam int unsigned NAME_BYTES      = 8;
  localparam int unsigned ID_BITS         = 16;

  localparam int unsigned NAME_W = 8 * NAME_BYTES;
  localparam int unsigned ID_W   = ID_BITS;

  localparam int unsigned IN_NAME_W  = 64;
  localparam int unsigned IN_ID_W    = 16;
  localparam int unsigned OUT_ID_W   = 16;
  localparam int unsigned OUT_CNT_W  = 6;

  localparam int unsigned CMD_FIFO_DEPTH = 2;

  typedef enum logic [1:0] {
    MODE_INIT   = 2'd0,
    MODE_ADD    = 2'd1,
    MODE_DEL    = 2'd2,
    MODE_LOOKUP = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_DUP     = 3'd1,
    ST_NO_ID   = 3'd2,
    ST_NO_NAME = 3'd3,
    ST_FULL    = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INIT1,
    S_SCAN,
    S_SHIFT,
    S_RESP
  } back_state_e;

  typedef struct packed {
    logic [NAME_W-1:0] name;
    logic [ID_W-1:0]   id;
  } entry_t;

  typedef struct packed {
    mode_e             op;
    logic [NAME_W-1:0] name;
    logic [ID_W-1:0]   eid;
    logic [ID_W-1:0]   pid;
  } cmd_t;

  // Keep bytes up to the first zero byte, at most NAME_BYTES of them.
  function automatic logic [NAME_W-1:0] name_cut(input logic [IN_NAME_W-1:0] v);
    logic [NAME_W-1:0] o;
    logic              live;
    o    = '0;
    live = 1'b1;
    for (int b = 0; b < NAME_BYTES; b++) begin
      if (v[8*b +: 8] == 8'h00) live = 1'b0;
      if (live) o[8*b +: 8] = v[8*b +: 8];
    end
    return o;
  endfunction

  localparam logic [NAME_W-1:0] NAME_DOTDOT = name_cut(64'h2E2E);
  localparam logic [NAME_W-1:0] NAME_DOT    = name_cut(64'h002E);

endpackage

// ===== rtl/core/det_front.sv =====
// ----------------------------------------------------------------------------
// det_front
// Input side: takes transactions, normalizes names and ids, builds commands.
// ----------------------------------------------------------------------------
module det_front (
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [1:0]                    mode_i,
  input  logic [det_pkg::IN_NAME_W-1:0] entry_name_i,
  input  logic [det_pkg::IN_ID_W-1:0]   entry_id_i,
  input  logic [det_pkg::IN_ID_W-1:0]   parent_id_i,
  input  logic                          q_full_i,
  output logic                          push_o,
  output det_pkg::cmd_t                 cmd_o
);

  assign in_stall_o = q_full_i;
  assign push_o     = in_valid_i && !q_full_i;

  always_comb begin
    cmd_o.op   = det_pkg::mode_e'(mode_i);
    // init stores fixed names, so the name field does not matter there
    cmd_o.name = det_pkg::name_cut(entry_name_i);
    cmd_o.eid  = det_pkg::ID_W'(entry_id_i);
    cmd_o.pid  = det_pkg::ID_W'(parent_id_i);
  end

endmodule

// ===== rtl/core/det_cmd_fifo.sv =====
// ----------------------------------------------------------------------------
// det_cmd_fifo
// Short command queue between front and back.
// ----------------------------------------------------------------------------
module det_cmd_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  det_pkg::cmd_t cmd_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          vld_o,
  output det_pkg::cmd_t cmd_o
);

  localparam int unsigned PW = (det_pkg::CMD_FIFO_DEPTH > 1) ?
                               $clog2(det_pkg::CMD_FIFO_DEPTH) : 1;
  localparam int unsigned CW = $clog2(det_pkg::CMD_FIFO_DEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(det_pkg::CMD_FIFO_DEPTH - 1);

  det_pkg::cmd_t slot_q [det_pkg::CMD_FIFO_DEPTH];
  logic [PW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          do_push, do_pop;

  assign full_o  = (cnt_q == CW'(det_pkg::CMD_FIFO_DEPTH));
  assign vld_o   = (cnt_q != '0);
  assign cmd_o   = slot_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && vld_o;

  always_comb begin
    wr_d  = do_push ? ((wr_q == LAST) ? '0 : wr_q + 1'b1) : wr_q;
    rd_d  = do_pop  ? ((rd_q == LAST) ? '0 : rd_q + 1'b1) : rd_q;
    cnt_d = cnt_q + CW'(do_push) - CW'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) slot_q[wr_q] <= cmd_i;
  end

endmodule

// ===== rtl/core/det_back.sv =====
// ----------------------------------------------------------------------------
// det_back
// Execution side: scans and edits the entry memory, holds the result register.
// ----------------------------------------------------------------------------
module det_back #(
  parameter int unsigned MAX_ENTRIES = det_pkg::MAX_ENTRIES_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           q_vld_i,
  input  det_pkg::cmd_t                  q_cmd_i,
  output logic                           q_pop_o,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [2:0]                     status_o,
  output logic [det_pkg::OUT_ID_W-1:0]   found_id_o,
  output logic [det_pkg::OUT_CNT_W-1:0]  entry_count_o
);

  localparam int unsigned AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int unsigned CW = $clog2(MAX_ENTRIES + 1);
  localparam logic [CW-1:0] CNT_MAX = CW'(MAX_ENTRIES);

  det_pkg::entry_t mem [MAX_ENTRIES];
  det_pkg::entry_t rd_q, wdata;
  logic            we;
  logic [AW-1:0]   waddr, raddr;

  det_pkg::back_state_e state_q, state_d;
  det_pkg::cmd_t        cmd_q, cmd_d;
  logic [CW-1:0]        cnt_q, cnt_d, iss_q, iss_d;
  logic                 pend_q, pend_d;
  logic [AW-1:0]        pidx_q, pidx_d;
  det_pkg::status_e     status_q, status_d;
  logic [det_pkg::ID_W-1:0] found_q, found_d;

  logic                 res_vld_q, res_vld_d;
  det_pkg::status_e     res_st_q, res_st_d;
  logic [det_pkg::ID_W-1:0] res_found_q, res_found_d;
  logic [CW-1:0]        res_cnt_q, res_cnt_d;

  logic scan_more, name_eq, id_eq, hit, miss, out_free;

  assign scan_more = (iss_q < cnt_q);
  assign name_eq   = (rd_q.name == cmd_q.name);
  assign id_eq     = (rd_q.id == cmd_q.eid);
  assign hit       = pend_q && ((cmd_q.op == det_pkg::MODE_DEL) ? id_eq : name_eq);
  assign miss      = !pend_q && !scan_more;
  assign out_free  = !res_vld_q || !out_stall_i;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      det_pkg::S_IDLE: begin
        if (q_vld_i) begin
          state_d = (q_cmd_i.op == det_pkg::MODE_INIT) ? det_pkg::S_INIT1 : det_pkg::S_SCAN;
        end
      end
      det_pkg::S_INIT1: state_d = det_pkg::S_RESP;
      det_pkg::S_SCAN: begin
        if (hit) begin
          state_d = (cmd_q.op == det_pkg::MODE_DEL) ? det_pkg::S_SHIFT : det_pkg::S_RESP;
        end else if (miss) begin
          state_d = det_pkg::S_RESP;
        end
      end
      det_pkg::S_SHIFT: begin
        if (!pend_q && !scan_more) state_d = det_pkg::S_RESP;
      end
      det_pkg::S_RESP: begin
        if (out_free) state_d = det_pkg::S_IDLE;
      end
      default: state_d = det_pkg::S_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    cmd_d       = cmd_q;
    cnt_d       = cnt_q;
    iss_d       = iss_q;
    pend_d      = 1'b0;
    pidx_d      = pidx_q;
    status_d    = status_q;
    found_d     = found_q;
    we          = 1'b0;
    waddr       = '0;
    wdata       = rd_q;
    raddr       = iss_q[AW-1:0];
    q_pop_o     = 1'b0;
    res_vld_d   = res_vld_q && out_stall_i;
    res_st_d    = res_st_q;
    res_found_d = res_found_q;
    res_cnt_d   = res_cnt_q;
    case (state_q)
      det_pkg::S_IDLE: begin
        if (q_vld_i) begin
          q_pop_o = 1'b1;
          cmd_d   = q_cmd_i;
          iss_d   = '0;
          found_d = '0;
          if (q_cmd_i.op == det_pkg::MODE_INIT) begin
            we         = 1'b1;
            waddr      = '0;
            wdata.name = det_pkg::NAME_DOTDOT;
            wdata.id   = q_cmd_i.pid;
          end
        end
      end
      det_pkg::S_INIT1: begin
        we         = 1'b1;
        waddr      = AW'(1);
        wdata.name = det_pkg::NAME_DOT;
        wdata.id   = cmd_q.eid;
        cnt_d      = CW'(2);
        status_d   = det_pkg::ST_OK;
      end
      det_pkg::S_SCAN: begin
        if (scan_more) begin
          iss_d  = iss_q + 1'b1;
          pend_d = 1'b1;
          pidx_d = iss_q[AW-1:0];
        end
        if (hit) begin
          case (cmd_q.op)
            det_pkg::MODE_DEL: begin
              iss_d  = CW'(pidx_q) + 1'b1;
              pend_d = 1'b0;
            end
            det_pkg::MODE_LOOKUP: begin
              found_d  = rd_q.id;
              status_d = det_pkg::ST_OK;
            end
            default: status_d = det_pkg::ST_DUP;
          endcase
        end else if (miss) begin
          case (cmd_q.op)
            det_pkg::MODE_DEL:    status_d = det_pkg::ST_NO_ID;
            det_pkg::MODE_LOOKUP: status_d = det_pkg::ST_NO_NAME;
            default: begin
              if (cnt_q >= CNT_MAX) begin
                status_d = det_pkg::ST_FULL;
              end else begin
                we         = 1'b1;
                waddr      = cnt_q[AW-1:0];
                wdata.name = cmd_q.name;
                wdata.id   = cmd_q.eid;
                cnt_d      = cnt_q + 1'b1;
                status_d   = det_pkg::ST_OK;
              end
            end
          endcase
        end
      end
      det_pkg::S_SHIFT: begin
        // read entry k+1, write it back at k in the next cycle
        if (scan_more) begin
          iss_d  = iss_q + 1'b1;
          pend_d = 1'b1;
          pidx_d = iss_q[AW-1:0];
        end
        if (pend_q) begin
          we    = 1'b1;
          waddr = pidx_q - 1'b1;
          wdata = rd_q;
        end else if (!scan_more) begin
          cnt_d    = cnt_q - 1'b1;
          status_d = det_pkg::ST_OK;
        end
      end
      det_pkg::S_RESP: begin
        if (out_free) begin
          res_vld_d   = 1'b1;
          res_st_d    = status_q;
          res_found_d = found_q;
          res_cnt_d   = cnt_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= det_pkg::S_IDLE;
      cnt_q     <= '0;
      pend_q    <= 1'b0;
      res_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      pend_q    <= pend_d;
      res_vld_q <= res_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q       <= cmd_d;
    iss_q       <= iss_d;
    pidx_q      <= pidx_d;
    status_q    <= status_d;
    found_q     <= found_d;
    res_st_q    <= res_st_d;
    res_found_q <= res_found_d;
    res_cnt_q   <= res_cnt_d;
  end

  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    rd_q <= mem[raddr];
  end

  assign out_valid_o   = res_vld_q;
  assign status_o      = res_st_q;
  assign found_id_o    = det_pkg::OUT_ID_W'(res_found_q);
  assign entry_count_o = det_pkg::OUT_CNT_W'(res_cnt_q);

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_MAX)
    else $error("entry count above table size");

  a_res_from_resp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_vld_d && !(res_vld_q && out_stall_i)) |-> (state_q == det_pkg::S_RESP))
    else $error("result loaded outside response state");

  a_full_at_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_vld_q && res_st_q == det_pkg::ST_FULL) |-> (res_cnt_q == CNT_MAX))
    else $error("table full reported below capacity");

  a_found_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_vld_q && res_found_q != '0) |-> (res_st_q == det_pkg::ST_OK))
    else $error("nonzero id with failing status");

  a_shift_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == det_pkg::S_SHIFT && (pend_q || scan_more)) |=> $stable(cnt_q))
    else $error("count changed in the middle of a shift");

endmodule

// ===== rtl/core/directory_entry_table.sv =====
// ----------------------------------------------------------------------------
// directory_entry_table
// Ordered table of directory entries (name, inode id) with init, add,
// delete-by-id and lookup-by-name.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid_i/in_stall_o carries one command per transaction:
//   mode_i, entry_name_i, entry_id_i, parent_id_i. Output channel
//   out_valid_o/out_stall_i carries one result per command: status_o,
//   found_id_o, entry_count_o. Results come back in command order.
//   A two-entry command queue sits between the input side and the
//   executor, so commands can be taken while a result waits.
//   The executor takes one command at a time and pops the next only after
//   the result of the one before has been loaded. With n entries in the
//   table it reads the entry memory one entry per cycle: add and lookup
//   scan up to n entries; delete scans to the hit, then shifts the rest.
//   A full table holds MAX_ENTRIES entries, 32 by default.
//   Reset empties the table (count zero) and the queue; memory contents are
//   left as they are and never read before being written.
//   While out_stall_i is high the result holds; the executor waits after
//   its next command and the queue then fills and raises in_stall_o.
// ----------------------------------------------------------------------------
module directory_entry_table #(
  parameter int unsigned MAX_ENTRIES = det_pkg::MAX_ENTRIES_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [1:0]                     mode_i,
  input  logic [det_pkg::IN_NAME_W-1:0]  entry_name_i,
  input  logic [det_pkg::IN_ID_W-1:0]    entry_id_i,
  input  logic [det_pkg::IN_ID_W-1:0]    parent_id_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [2:0]                     status_o,
  output logic [det_pkg::OUT_ID_W-1:0]   found_id_o,
  output logic [det_pkg::OUT_CNT_W-1:0]  entry_count_o
);

  logic          q_full, push, q_vld, q_pop;
  det_pkg::cmd_t push_cmd, q_cmd;

  det_front u_front (
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .mode_i       (mode_i),
    .entry_name_i (entry_name_i),
    .entry_id_i   (entry_id_i),
    .parent_id_i  (parent_id_i),
    .q_full_i     (q_full),
    .push_o       (push),
    .cmd_o        (push_cmd)
  );

  det_cmd_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .cmd_i  (push_cmd),
    .full_o (q_full),
    .pop_i  (q_pop),
    .vld_o  (q_vld),
    .cmd_o  (q_cmd)
  );

  det_back #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_vld_i       (q_vld),
    .q_cmd_i       (q_cmd),
    .q_pop_o       (q_pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .status_o      (status_o),
    .found_id_o    (found_id_o),
    .entry_count_o (entry_count_o)
  );

endmodule
